@@ design/apd_pkg.sv @@
// Package: shared constants and types for the audio packet deframer.
`timescale 1ns / 1ps

package apd_pkg;

    // Header layout, little-endian fields
    localparam int HDR_BYTES = 12;
    localparam int FILL_W    = 4;

    localparam logic [31:0] RST_SYNC_WORD   = 32'h314B_5053;
    localparam logic [15:0] RST_RATE        = 16'd16000;
    localparam logic [15:0] RST_MAX_SAMPLES = 16'd1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_WORD   = 2'd0,
        CFG_RATE        = 2'd1,
        CFG_MAX_SAMPLES = 2'd2
    } cfg_idx_t;

    typedef logic [7:0] byte_t;

endpackage

@@ design/audio_packet_deframer.sv @@
// Top level: byte-serial sync-word packet deframer producing 16-bit samples.
`timescale 1ns / 1ps

// Takes one stream byte per word on the input channel and hunts for a
// 12-byte header: 32-bit sync word, 16-bit rate, 16-bit sample count
// (nonzero, even, at most max_samples) and a 32-bit sequence number, all
// little-endian. While hunting, the oldest byte slides out of the window on
// every new byte. Once a header matches, the following bytes are paired low
// byte first into signed samples; each sample leaves as one output word
// tagged with the frame's sequence number, and the last one of the frame
// sets last_in_frame, after which the hunt restarts with an empty window.
// Rate: one byte per clock cycle while the output register is not full and
// stalled. A byte passes an input register, then the window compare and
// payload logic, then the output register, which takes the sample of a high byte.
// The input register holds a byte only while the output register is full
// and stalled. Configuration is written through cfg_we / cfg_index /
// cfg_data and must only change while no words are in flight; indexes
// beyond the register list are ignored.
module audio_packet_deframer
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic [apd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [apd_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         data_byte,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [15:0]                 sample,
    output logic [31:0]                        frame_sequence,
    output logic                               last_in_frame
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [31:0] sync_word_reg;
    logic [15:0] rate_reg;
    logic [15:0] max_samples_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg   <= apd_pkg::RST_SYNC_WORD;
            rate_reg        <= apd_pkg::RST_RATE;
            max_samples_reg <= apd_pkg::RST_MAX_SAMPLES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                apd_pkg::CFG_SYNC_WORD:   sync_word_reg   <= cfg_data[31:0];
                apd_pkg::CFG_RATE:        rate_reg        <= cfg_data[15:0];
                apd_pkg::CFG_MAX_SAMPLES: max_samples_reg <= cfg_data[15:0];
                default:                  ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    logic          in_valid_reg;
    logic          in_valid_next;
    apd_pkg::byte_t in_byte_reg;
    logic          in_take;
    logic          fire;
    logic          out_valid_reg;

    // Process the held byte unless the output register is full and stalled.
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= data_byte;
    end

    // ---------------------------------------------------------------
    // Deframer state
    // ---------------------------------------------------------------
    apd_pkg::byte_t            win_reg [apd_pkg::HDR_BYTES];
    apd_pkg::byte_t            win_next [apd_pkg::HDR_BYTES];
    logic [apd_pkg::FILL_W-1:0] fill_reg;
    logic [apd_pkg::FILL_W-1:0] fill_next;
    logic                      in_payload_reg;
    logic                      in_payload_next;
    logic [15:0]               left_reg;
    logic [15:0]               left_next;
    apd_pkg::byte_t            low_hold_reg;
    apd_pkg::byte_t            low_hold_next;
    logic                      phase_reg;
    logic                      phase_next;
    logic [31:0]               seq_reg;
    logic [31:0]               seq_next;

    // Header fields of the window after the new byte slides in
    logic [31:0] hdr_sync;
    logic [15:0] hdr_rate;
    logic [15:0] hdr_count;
    logic [31:0] hdr_seq;
    logic        hdr_hit;
    logic        full_next;

    // Result of this byte
    logic        res_valid;
    logic [15:0] res_sample;
    logic        res_last;

    always_comb
    begin
        for (int i = 0; i < apd_pkg::HDR_BYTES - 1; i++)
            win_next[i] = win_reg[i + 1];
        win_next[apd_pkg::HDR_BYTES - 1] = in_byte_reg;
    end

    assign hdr_sync  = {win_next[3], win_next[2], win_next[1], win_next[0]};
    assign hdr_rate  = {win_next[5], win_next[4]};
    assign hdr_count = {win_next[7], win_next[6]};
    assign hdr_seq   = {win_next[11], win_next[10], win_next[9], win_next[8]};

    // Window is full once the incoming byte is counted
    assign full_next = (fill_reg >= apd_pkg::FILL_W'(apd_pkg::HDR_BYTES - 1));

    assign hdr_hit = full_next
                  && (hdr_sync == sync_word_reg)
                  && (hdr_rate == rate_reg)
                  && (hdr_count != 16'd0)
                  && !hdr_count[0]
                  && (hdr_count <= max_samples_reg);

    always_comb
    begin
        fill_next       = fill_reg;
        in_payload_next = in_payload_reg;
        left_next       = left_reg;
        low_hold_next   = low_hold_reg;
        phase_next      = phase_reg;
        seq_next        = seq_reg;
        res_valid       = 1'b0;
        res_sample      = {in_byte_reg, low_hold_reg};
        res_last        = 1'b0;

        if (!in_payload_reg)
        begin
            if (full_next)
                fill_next = apd_pkg::FILL_W'(apd_pkg::HDR_BYTES);
            else
                fill_next = fill_reg + apd_pkg::FILL_W'(1);
            if (hdr_hit)
            begin
                left_next       = hdr_count;
                seq_next        = hdr_seq;
                in_payload_next = 1'b1;
                phase_next      = 1'b0;
                low_hold_next   = 8'd0;
                fill_next       = '0;
            end
        end
        else if (!phase_reg)
        begin
            low_hold_next = in_byte_reg;
            phase_next    = 1'b1;
        end
        else
        begin
            phase_next = 1'b0;
            res_valid  = 1'b1;
            // a count of one or zero ends the frame
            if (left_reg <= 16'd1)
            begin
                left_next       = 16'd0;
                res_last        = 1'b1;
                in_payload_next = 1'b0;
                fill_next       = '0;
            end
            else
            begin
                left_next = left_reg - 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < apd_pkg::HDR_BYTES; i++)
                win_reg[i] <= 8'd0;
            fill_reg       <= '0;
            in_payload_reg <= 1'b0;
            left_reg       <= 16'd0;
            low_hold_reg   <= 8'd0;
            phase_reg      <= 1'b0;
            seq_reg        <= 32'd0;
        end
        else if (fire)
        begin
            // window only shifts while hunting
            if (!in_payload_reg)
            begin
                for (int i = 0; i < apd_pkg::HDR_BYTES; i++)
                    win_reg[i] <= win_next[i];
            end
            fill_reg       <= fill_next;
            in_payload_reg <= in_payload_next;
            left_reg       <= left_next;
            low_hold_reg   <= low_hold_next;
            phase_reg      <= phase_next;
            seq_reg        <= seq_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic        out_valid_next;
    logic [15:0] sample_reg;
    logic [31:0] out_seq_reg;
    logic        last_reg;
    logic        out_load;

    assign out_load = fire && res_valid;

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_reg  <= res_sample;
            out_seq_reg <= seq_reg;
            last_reg    <= res_last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sample         = signed'(sample_reg);
    assign frame_sequence = out_seq_reg;
    assign last_in_frame  = last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= apd_pkg::FILL_W'(apd_pkg::HDR_BYTES))
        else $error("window fill count out of range");

    a_payload_empty_win: assert property (@(posedge clk) disable iff (!rst_n)
        in_payload_reg |-> (fill_reg == '0))
        else $error("window not emptied while taking payload");

    a_hdr_enters_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !in_payload_reg && hdr_hit) |=>
            (in_payload_reg && !phase_reg && (left_reg != 16'd0)))
        else $error("header match did not start a frame");

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_last) |=> (!in_payload_reg && out_valid && last_in_frame))
        else $error("last sample did not end the frame");

    a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !fire)
        else $error("byte processed while output register blocked");

endmodule
